@@ hw/rtl/mvm_pkg.sv @@
// Package for the matrix-vector multiplier: opcodes, controller states,
// command and status structs, and the relaxation diagonal table.
// No dependencies.
`default_nettype none

package mvm_pkg;

    localparam int DIM_DEF       = 19;
    localparam int FRAC_BITS_DEF = 16;
    localparam int RELAX_N       = 5;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_WR_ENTRY = 3'd0,
        OP_WR_VEC   = 3'd1,
        OP_ALL_ROWS = 3'd2,
        OP_ONE_ROW  = 3'd3,
        OP_RELAX    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RELAX,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        WD_IN,
        WD_HELD,
        WD_ZERO
    } t_wd_sel;

    typedef struct packed {
        logic       mat_we;
        logic       vec_we;
        t_wd_sel    wd_sel;
        logic       load_value;
        logic       rd_en;
        logic       acc_clear;
        logic       rnd_en;
        logic       out_load;
        logic       out_last;
        logic [4:0] out_row;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic pipe_busy;
    } t_sts;

    function automatic logic [3:0] relax_diag(input logic [2:0] idx);
        logic [3:0] d;
        unique case (idx)
            3'd0:    d = 4'd9;
            3'd1:    d = 4'd11;
            3'd2:    d = 4'd13;
            3'd3:    d = 4'd14;
            3'd4:    d = 4'd15;
            default: d = 4'd15;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mvm_if.sv @@
// Handshake interfaces for the input command words and the result words.
// No dependencies.
`default_nettype none

interface mvm_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  op;
    logic        [4:0]  row;
    logic        [4:0]  col;
    logic signed [31:0] value;

    modport source(output valid, output op, output row, output col, output value,
                   input ready);
    modport sink(input valid, input op, input row, input col, input value,
                 output ready);
endinterface

interface mvm_out_if;
    logic               valid;
    logic               ready;
    logic        [4:0]  out_row;
    logic signed [31:0] product;
    logic               saturated;
    logic               last;

    modport source(output valid, output out_row, output product, output saturated,
                   output last, input ready);
    modport sink(input valid, input out_row, input product, input saturated,
                 input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/matrix_vector_multiply_19_top.sv @@
// Dense DIM by DIM matrix-vector multiplier in signed Q16.16, one shared multiplier.
// A row product runs through DIM multiply-accumulates, the drain, rounding and output; all
// rows do this for each row in turn, and a stall of the output holds it. One word at a time.
// After reset a clearing pass zeroes both memories, during which no word is accepted.
// Depends on mvm_pkg, mvm_if, mvm_ctrl, mvm_datapath.
`default_nettype none

module matrix_vector_multiply_19_top #(
    parameter int DIM       = mvm_pkg::DIM_DEF,
    parameter int FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mvm_in_if.sink     i_in,
    mvm_out_if.source  o_out
);
    import mvm_pkg::*;

    localparam int DEPTH  = DIM * DIM;
    localparam int MAT_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VEC_AW = (DIM > 1) ? $clog2(DIM) : 1;

    t_cmd              cmd;
    t_sts              sts;
    logic [MAT_AW-1:0] mat_waddr;
    logic [MAT_AW-1:0] mat_raddr;
    logic [VEC_AW-1:0] vec_waddr;
    logic [VEC_AW-1:0] vec_raddr;

    mvm_ctrl #(
        .DIM(DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_mat_waddr (mat_waddr),
        .o_mat_raddr (mat_raddr),
        .o_vec_waddr (vec_waddr),
        .o_vec_raddr (vec_raddr)
    );

    mvm_datapath #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_value         (i_in.value),
        .i_mat_waddr     (mat_waddr),
        .i_mat_raddr     (mat_raddr),
        .i_vec_waddr     (vec_waddr),
        .i_vec_raddr     (vec_raddr),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_row       (o_out.out_row),
        .o_out_product   (o_out.product),
        .o_out_saturated (o_out.saturated),
        .o_out_last      (o_out.last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mvm_datapath.sv @@
// Datapath: coefficient and vector memories, the shared multiplier, the wide
// accumulator, rounding, saturation and the output register. Uses mvm_pkg.
`default_nettype none

module mvm_datapath #(
    parameter int DIM       = mvm_pkg::DIM_DEF,
    parameter int FRAC_BITS = mvm_pkg::FRAC_BITS_DEF,
    localparam int DEPTH    = DIM * DIM,
    localparam int MAT_AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int VEC_AW   = (DIM > 1) ? $clog2(DIM) : 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mvm_pkg::t_cmd       i_cmd,
    output mvm_pkg::t_sts       o_sts,
    input  wire signed [31:0]   i_value,
    input  wire [MAT_AW-1:0]    i_mat_waddr,
    input  wire [MAT_AW-1:0]    i_mat_raddr,
    input  wire [VEC_AW-1:0]    i_vec_waddr,
    input  wire [VEC_AW-1:0]    i_vec_raddr,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output logic [4:0]          o_out_row,
    output logic signed [31:0]  o_out_product,
    output logic                o_out_saturated,
    output logic                o_out_last
);
    import mvm_pkg::*;

    localparam int ACC_W = 65 + $clog2(DIM);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    logic        [31:0]      r_mat_mem [DEPTH];
    logic        [31:0]      r_vec_mem [DIM];
    logic signed [31:0]      r_mat_q;
    logic signed [31:0]      r_vec_q;
    logic signed [31:0]      r_value;
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_rnd;
    logic                    r_v1;
    logic                    r_v2;
    logic [31:0]             wdata;
    logic                    sat;
    logic [31:0]             clipped;

    always_comb begin
        unique case (i_cmd.wd_sel)
            WD_IN:   wdata = i_value;
            WD_HELD: wdata = r_value;
            default: wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we) begin
            r_mat_mem[i_mat_waddr] <= wdata;
        end
        if (i_cmd.vec_we) begin
            r_vec_mem[i_vec_waddr] <= wdata;
        end
        r_mat_q <= r_mat_mem[i_mat_raddr];
        r_vec_q <= r_vec_mem[i_vec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_value) begin
            r_value <= i_value;
        end
        r_prod <= r_mat_q * r_vec_q;
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.rnd_en) begin
            r_rnd <= (r_acc + HALF) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    // The rounded sum fits in 32 bits only if all bits from 31 upward agree.
    always_comb begin
        sat = !((&r_rnd[ACC_W-1:31]) || !(|r_rnd[ACC_W-1:31]));
        if (!sat) begin
            clipped = r_rnd[31:0];
        end else if (r_rnd[ACC_W-1]) begin
            clipped = Q_MIN;
        end else begin
            clipped = Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_row       <= i_cmd.out_row;
            o_out_product   <= clipped;
            o_out_saturated <= sat;
            o_out_last      <= i_cmd.out_last;
        end
    end

    assign o_sts.out_free  = !o_out_valid || i_out_ready;
    assign o_sts.pipe_busy = r_v1 || r_v2;

endmodule

`default_nettype wire

@@ hw/rtl/mvm_ctrl.sv @@
// Controller: state machine that decodes command words, sequences the
// clearing pass, relaxation writes and row products. Uses mvm_pkg.
`default_nettype none

module mvm_ctrl #(
    parameter int DIM      = mvm_pkg::DIM_DEF,
    localparam int DEPTH   = DIM * DIM,
    localparam int MAT_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int VEC_AW  = (DIM > 1) ? $clog2(DIM) : 1
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire [2:0]         i_op,
    input  wire [4:0]         i_row,
    input  wire [4:0]         i_col,
    output logic              o_in_ready,
    output mvm_pkg::t_cmd     o_cmd,
    input  mvm_pkg::t_sts     i_sts,
    output logic [MAT_AW-1:0] o_mat_waddr,
    output logic [MAT_AW-1:0] o_mat_raddr,
    output logic [VEC_AW-1:0] o_vec_waddr,
    output logic [VEC_AW-1:0] o_vec_raddr
);
    import mvm_pkg::*;

    t_state            r_state, n_state;
    logic [MAT_AW-1:0] r_clr, n_clr;
    logic [MAT_AW-1:0] r_addr, n_addr;
    logic [VEC_AW-1:0] r_col, n_col;
    logic [VEC_AW-1:0] r_row, n_row;
    logic [2:0]        r_rlx, n_rlx;
    logic              r_single, n_single;
    logic              r_drain, n_drain;
    logic              accept;
    logic              row_ok;
    logic              col_ok;
    logic [3:0]        diag;
    logic              row_last;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign row_ok   = 32'(i_row) < DIM;
    assign col_ok   = 32'(i_col) < DIM;
    assign diag     = relax_diag(r_rlx);
    assign row_last = r_single || (r_row == VEC_AW'(DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_addr   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_rlx    <= '0;
            r_single <= 1'b0;
            r_drain  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_addr   <= n_addr;
            r_col    <= n_col;
            r_row    <= n_row;
            r_rlx    <= n_rlx;
            r_single <= n_single;
            r_drain  <= n_drain;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_rlx       = r_rlx;
        n_single    = r_single;
        n_drain     = r_drain;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.wd_sel = WD_ZERO;
        o_mat_waddr = r_clr;
        o_mat_raddr = r_addr;
        o_vec_waddr = VEC_AW'(r_clr);
        o_vec_raddr = r_col;

        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.mat_we = 1'b1;
                o_cmd.vec_we = 32'(r_clr) < DIM;
                n_clr = MAT_AW'(r_clr + 1'b1);
                if (r_clr == MAT_AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.acc_clear = 1'b1;
                o_cmd.wd_sel    = WD_IN;
                o_mat_waddr     = MAT_AW'(32'(i_row) * DIM + 32'(i_col));
                o_vec_waddr     = VEC_AW'(i_col);
                if (accept) begin
                    unique case (t_op'(i_op))
                        OP_WR_ENTRY: begin
                            o_cmd.mat_we = row_ok && col_ok;
                        end
                        OP_WR_VEC: begin
                            o_cmd.vec_we = col_ok;
                        end
                        OP_ALL_ROWS: begin
                            n_addr   = '0;
                            n_row    = '0;
                            n_col    = '0;
                            n_single = 1'b0;
                            n_state  = ST_MAC;
                        end
                        OP_ONE_ROW: begin
                            if (row_ok) begin
                                n_addr   = MAT_AW'(32'(i_row) * DIM);
                                n_row    = VEC_AW'(i_row);
                                n_col    = '0;
                                n_single = 1'b1;
                                n_state  = ST_MAC;
                            end
                        end
                        OP_RELAX: begin
                            o_cmd.load_value = 1'b1;
                            n_rlx   = '0;
                            n_state = ST_RELAX;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RELAX: begin
                o_cmd.wd_sel = WD_HELD;
                o_cmd.mat_we = 32'(diag) < DIM;
                o_mat_waddr  = MAT_AW'(32'(diag) * (DIM + 1));
                n_rlx = r_rlx + 3'd1;
                if (r_rlx == 3'(RELAX_N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAC: begin
                o_cmd.rd_en = 1'b1;
                n_addr = MAT_AW'(r_addr + 1'b1);
                n_col  = VEC_AW'(r_col + 1'b1);
                if (r_col == VEC_AW'(DIM - 1)) begin
                    n_drain = 1'b0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain && !i_sts.pipe_busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.rnd_en    = 1'b1;
                o_cmd.acc_clear = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.out_row  = 5'(r_row);
                o_cmd.out_last = row_last;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (row_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row   = VEC_AW'(r_row + 1'b1);
                        n_col   = '0;
                        n_state = ST_MAC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/mvm_result_checker.sv @@
// Checker for the matrix-vector multiplier: it keeps its own copy of the matrix and vector,
// predicts every dot product from the accepted command words and compares the result words.
// Depends on mvm_pkg and mvm_if.
`timescale 1ns / 1ps

module mvm_result_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    mvm_in_if    i_in,
    mvm_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);
    import mvm_pkg::*;

    localparam int DIM  = DIM_DEF;
    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic [4:0]  row;
        logic [31:0] product;
        logic        saturated;
        logic        last;
    } t_dot_result;

    logic [31:0] coef [DIM][DIM];
    logic [31:0] vec [DIM];
    t_dot_result expected_dots[$];
    t_dot_result seen;
    t_dot_result want;
    int          errors = 0;

    function automatic t_dot_result row_dot_product(input int r, input logic last);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] p;
        logic signed [71:0] acc;
        logic signed [71:0] scaled;
        t_dot_result        res;
        acc = '0;
        for (int j = 0; j < DIM; j++) begin
            a   = coef[r][j];
            b   = vec[j];
            p   = a * b;
            acc = acc + p;
        end
        acc    = acc + (72'sd1 <<< (FRAC - 1));
        scaled = acc >>> FRAC;
        res.row = r[4:0];
        res.last = last;
        if (scaled > $signed({40'b0, Q_MAX})) begin
            res.product   = Q_MAX;
            res.saturated = 1'b1;
        end else if (scaled < $signed({{40{1'b1}}, Q_MIN})) begin
            res.product   = Q_MIN;
            res.saturated = 1'b1;
        end else begin
            res.product   = scaled[31:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                vec[r] = '0;
                for (int c = 0; c < DIM; c++) coef[r][c] = '0;
            end
            expected_dots.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                seen = '{i_out.out_row, i_out.product, i_out.saturated, i_out.last};
                if (expected_dots.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, row %0d product %h sat %b last %b",
                             $time, seen.row, seen.product, seen.saturated, seen.last);
                end else begin
                    want = expected_dots.pop_front();
                    if (seen.row !== want.row || seen.product !== want.product ||
                        seen.saturated !== want.saturated || seen.last !== want.last) begin
                        errors++;
                        $display({"%0t: expected row %0d product %h sat %b last %b, ",
                                  "got row %0d product %h sat %b last %b"},
                                 $time, want.row, want.product, want.saturated, want.last,
                                 seen.row, seen.product, seen.saturated, seen.last);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (t_op'(i_in.op))
                    OP_WR_ENTRY: begin
                        if (i_in.row < DIM && i_in.col < DIM)
                            coef[i_in.row][i_in.col] = i_in.value;
                    end
                    OP_WR_VEC: begin
                        if (i_in.col < DIM) vec[i_in.col] = i_in.value;
                    end
                    OP_ALL_ROWS: begin
                        for (int r = 0; r < DIM; r++)
                            expected_dots.push_back(row_dot_product(r, r == DIM - 1));
                    end
                    OP_ONE_ROW: begin
                        if (i_in.row < DIM)
                            expected_dots.push_back(row_dot_product(int'(i_in.row), 1'b1));
                    end
                    OP_RELAX: begin
                        coef[9][9]   = i_in.value;
                        coef[11][11] = i_in.value;
                        coef[13][13] = i_in.value;
                        coef[14][14] = i_in.value;
                        coef[15][15] = i_in.value;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= expected_dots.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the matrix-vector multiplier testbench: clock, reset, directed and random command
// words in bursts, a stalling result receiver and the verdict.
// Depends on mvm_pkg, mvm_if, matrix_vector_multiply_19_top and mvm_result_checker.
`timescale 1ns / 1ps

module testbench;
    import mvm_pkg::*;

    localparam int         DIM            = DIM_DEF;
    localparam int         STIM_WORDS     = 320;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   awaited;
    int   burst_left = 0;

    mvm_in_if  in_ch();
    mvm_out_if out_ch();

    matrix_vector_multiply_19_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mvm_result_checker dot_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (mismatches),
        .o_pending (awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : result_stalls
        int mode;
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(3, 0);
            repeat ($urandom_range(80, 10)) begin
                @(posedge i_clk);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(3, 0) != 0);
                    2: out_ch.ready <= 1'($urandom_range(1, 0));
                    default: begin
                        if (stall_left == 0) begin
                            out_ch.ready <= 1'b1;
                            stall_left = $urandom_range(20, 4);
                        end else begin
                            out_ch.ready <= 1'b0;
                            stall_left--;
                        end
                    end
                endcase
            end
        end
    end

    function automatic logic [4:0] pick_index();
        if ($urandom_range(9, 0) == 0) return 5'($urandom_range(31, DIM));
        return 5'($urandom_range(DIM - 1, 0));
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [4:0] row,
                             input logic [4:0] col, input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8, 0);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    initial begin : stimulus
        int          effective;
        int          pick;
        logic [2:0]  op;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [31:0] value;
        effective = 0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_WR_ENTRY;
        in_ch.row   <= '0;
        in_ch.col   <= '0;
        in_ch.value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Saturation both ways, rounding ties on either sign, ignored words, then every row.
        send_word(OP_WR_ENTRY, 5'd0, 5'd0, Q_MAX);
        send_word(OP_WR_VEC, 5'd0, 5'd0, Q_MAX);
        send_word(OP_ONE_ROW, 5'd0, 5'd0, 32'd0);
        send_word(OP_WR_ENTRY, 5'd18, 5'd18, Q_MIN);
        send_word(OP_WR_VEC, 5'd0, 5'd18, Q_MAX);
        send_word(OP_ONE_ROW, 5'd18, 5'd0, 32'd0);
        send_word(OP_WR_ENTRY, 5'd1, 5'd1, 32'd1);
        send_word(OP_WR_VEC, 5'd0, 5'd1, 32'h0000_8000);
        send_word(OP_WR_ENTRY, 5'd2, 5'd2, 32'hFFFF_FFFF);
        send_word(OP_WR_VEC, 5'd0, 5'd2, 32'h0000_8000);
        send_word(OP_WR_ENTRY, 5'd19, 5'd3, Q_MAX);
        send_word(OP_WR_ENTRY, 5'd3, 5'd31, Q_MAX);
        send_word(OP_WR_VEC, 5'd0, 5'd31, Q_MIN);
        send_word(OP_ONE_ROW, 5'd19, 5'd0, 32'd0);
        send_word(OP_ONE_ROW, 5'd31, 5'd31, 32'hFFFF_FFFF);
        for (int k = int'(OP_SPARE_FIRST); k <= int'(OP_SPARE_LAST); k++)
            send_word(3'(k), 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_word(OP_RELAX, 5'd0, 5'd0, 32'h0001_8000);
        send_word(OP_WR_VEC, 5'd0, 5'd13, 32'h0002_0000);
        send_word(OP_ALL_ROWS, 5'd0, 5'd0, 32'd0);

        while (effective < STIM_WORDS) begin
            pick = $urandom_range(99, 0);
            if (pick < 40)      op = OP_WR_ENTRY;
            else if (pick < 60) op = OP_WR_VEC;
            else if (pick < 64) op = OP_RELAX;
            else if (pick < 86) op = OP_ONE_ROW;
            else if (pick < 92) op = OP_ALL_ROWS;
            else                op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            row = pick_index();
            col = pick_index();
            case ($urandom_range(9, 0))
                0:       value = Q_MAX;
                1:       value = Q_MIN;
                2, 3, 4: value = $urandom;
                default: value = 32'($urandom_range(262143, 0)) - 32'd131072;
            endcase
            send_word(op, row, col, value);
            effective++;
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
